[rtl/srr_pkg.sv]
// Shared widths and result codes for the selective repeat receiver.
package srr_pkg;

  localparam int CHK_W      = 32;
  localparam int SEQ_W      = 16;
  localparam int PAY_W      = 64;
  localparam int KIND_W     = 3;
  localparam int ACK_SLOT_W = 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_CORRUPT   = 3'd0;
  localparam kind_t KIND_ACK_SEEN  = 3'd1;
  localparam kind_t KIND_STORED    = 3'd2;
  localparam kind_t KIND_OUTSIDE   = 3'd3;
  localparam kind_t KIND_DUPLICATE = 3'd4;
  localparam kind_t KIND_DELIVERED = 3'd5;

  localparam logic [SEQ_W-1:0] SEQ_ACK   = 16'hFFFF;
  localparam logic [CHK_W-1:0] SUM_MASK  = 32'h00FF_FFFF;
  localparam logic [7:0]       CHAR_ZERO = 8'h30;
  localparam logic [7:0]       CHAR_NINE = 8'h39;

endpackage

[rtl/selective_repeat_receiver.sv]
// Selective repeat ARQ receiver: checksum check, window store and in-order release.
// Each transaction is one received packet. The block takes a packet only while it is
// idle; the checksum is built by one shared adder, two payload bytes a cycle. A packet
// passes through an accept step, the checksum steps and a status step, then for each
// released payload a read on the slot memory's single read port and a load of the
// output register. The status and send steps wait while the output is stalled. The
// status result always comes first; its last flag is set when nothing is released.
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int WINDOW = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CHK_W-1:0] rx_checksum,
  input  logic signed [SEQ_W-1:0] rx_seq,
  input  logic [PAY_W-1:0]        rx_payload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KIND_W-1:0]       kind,
  output logic                    ack_req,
  output logic signed [SEQ_W-1:0] seq_out,
  output logic [ACK_SLOT_W-1:0]   ack_slot,
  output logic [PAY_W-1:0]        payload_out,
  output logic                    last
);

  localparam int SPAN = 2 * WINDOW;
  localparam int SW   = $clog2(SPAN);
  localparam int SLW  = $clog2(WINDOW);

  localparam logic [SW-1:0]    WIN_S   = SW'(WINDOW);
  localparam logic [SW-1:0]    LAST_S  = SW'(SPAN - 1);
  localparam logic [SW:0]      SPAN_X  = (SW+1)'(SPAN);
  localparam logic [SW:0]      WIN_X   = (SW+1)'(WINDOW);
  localparam logic [SLW-1:0]   LAST_SL = SLW'(WINDOW - 1);
  localparam logic [7:0]       WIN8    = 8'(WINDOW);
  localparam logic [SEQ_W-1:0] SPAN_Q  = SEQ_W'(SPAN);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_STATUS = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SEND   = 3'd4;

  logic [2:0]       state;
  logic [1:0]       cnt;
  logic [CHK_W-1:0] sum;
  logic [CHK_W-1:0] chk;
  logic [SEQ_W-1:0] seq;
  logic [PAY_W-1:0] pay;
  logic [SW-1:0]    exp_seq;
  logic [WINDOW-1:0] slot_full;
  logic [PAY_W-1:0] rd_data;
  logic [PAY_W-1:0] mem [WINDOW];

  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [CHK_W-1:0] sum_next;
  logic             load;
  logic             emit;
  logic [SW-1:0]    s;
  logic [SW:0]      diff;
  logic [SLW-1:0]   slot;
  logic [SLW-1:0]   exp_slot;
  logic [SLW-1:0]   nxt_slot;
  logic [SW-1:0]    exp_next;
  logic             sum_ok;
  logic             is_ack;
  logic             in_win;
  logic             stored;
  logic             rel;
  logic [7:0]       digit;
  logic [ACK_SLOT_W-1:0] ack_val;
  kind_t            st_kind;

  assign in_ready = (state == ST_IDLE);
  assign load     = !out_valid || out_ready;
  assign emit     = load && (state == ST_STATUS || state == ST_SEND);

  assign b0       = pay[{cnt, 4'd0} +: 8];
  assign b1       = pay[{cnt, 4'd8} +: 8];
  assign sum_next = sum + {{(CHK_W-8){b0[7]}}, b0} + {{(CHK_W-8){b1[7]}}, b1};

  always_comb begin
    s        = seq[SW-1:0];
    diff     = (s >= exp_seq) ? {1'b0, s} - {1'b0, exp_seq}
                              : {1'b0, s} + SPAN_X - {1'b0, exp_seq};
    slot     = SLW'((s >= WIN_S) ? s - WIN_S : s);
    exp_slot = SLW'((exp_seq >= WIN_S) ? exp_seq - WIN_S : exp_seq);
    nxt_slot = (exp_slot == LAST_SL) ? '0 : exp_slot + 1'b1;
    exp_next = (exp_seq == LAST_S) ? '0 : exp_seq + 1'b1;
    sum_ok   = ((sum ^ SUM_MASK) == chk);
    is_ack   = (seq == SEQ_ACK);
    in_win   = !seq[SEQ_W-1] && (seq < SPAN_Q) && (diff < WIN_X);
    stored   = sum_ok && !is_ack && in_win && !slot_full[slot];
    rel      = stored && ((slot == exp_slot) || slot_full[exp_slot]);
    digit    = 8'h00;
    if (pay[7:0] >= CHAR_ZERO && pay[7:0] <= CHAR_NINE) begin
      digit = pay[7:0] - CHAR_ZERO;
    end
    for (int i = 0; i < 5; i++) begin
      if (digit >= WIN8) begin
        digit = digit - WIN8;
      end
    end
    ack_val = digit[ACK_SLOT_W-1:0];
    if (!sum_ok) begin
      st_kind = KIND_CORRUPT;
    end else if (is_ack) begin
      st_kind = KIND_ACK_SEEN;
    end else if (!in_win) begin
      st_kind = KIND_OUTSIDE;
    end else if (slot_full[slot]) begin
      st_kind = KIND_DUPLICATE;
    end else begin
      st_kind = KIND_STORED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      exp_seq   <= '0;
      slot_full <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SUM;
            cnt   <= '0;
          end
        end
        ST_SUM: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd3) begin
            state <= ST_STATUS;
          end
        end
        ST_STATUS: begin
          if (load) begin
            if (stored) begin
              slot_full[slot] <= 1'b1;
            end
            state <= rel ? ST_READ : ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (load) begin
            slot_full[exp_slot] <= 1'b0;
            exp_seq             <= exp_next;
            state               <= slot_full[nxt_slot] ? ST_READ : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      chk <= rx_checksum;
      seq <= rx_seq;
      pay <= rx_payload;
      sum <= {{(CHK_W-SEQ_W){rx_seq[SEQ_W-1]}}, rx_seq};
    end else if (state == ST_SUM) begin
      sum <= sum_next;
    end
    if (state == ST_STATUS && load) begin
      kind        <= st_kind;
      ack_req     <= sum_ok && !is_ack;
      seq_out     <= (sum_ok && !is_ack) ? seq : '0;
      ack_slot    <= (sum_ok && is_ack) ? ack_val : '0;
      payload_out <= '0;
      last        <= !rel;
    end else if (state == ST_SEND && load) begin
      kind        <= KIND_DELIVERED;
      ack_req     <= 1'b0;
      seq_out     <= {{(SEQ_W-SW){1'b0}}, exp_seq};
      ack_slot    <= '0;
      payload_out <= rd_data;
      last        <= !slot_full[nxt_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_STATUS && load && stored) begin
      mem[slot] <= pay;
    end
    if (state == ST_READ) begin
      rd_data <= mem[exp_slot];
    end
  end

`ifndef SYNTHESIS
  a_release_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEND |-> slot_full[exp_slot])
    else $error("release from an empty slot");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second packet taken while busy");

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, exp_seq} < SPAN_X)
    else $error("expected sequence out of range");

  a_expected_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !slot_full[exp_slot])
    else $error("expected slot left full while idle");
`endif

endmodule
